// ----- src/cswg_pkg.sv -----
package cswg_pkg;

  // Field and register widths
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 24;
  localparam int COEF_W  = 24;
  localparam int PHASE_W = 32;
  localparam int TERM_W  = 3;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;

  // Build constants
  localparam int MAX_TERMS  = 5;
  localparam int INDEX_BITS = 12;
  localparam int TABLE_BITS = 10;
  localparam int COEF_REGS  = 5;
  localparam int NTERMS     = (MAX_TERMS < COEF_REGS) ? MAX_TERMS : COEF_REGS;

  // Quarter-wave cosine table, Q22 magnitudes
  localparam int TBL_SIZE    = 1 << TABLE_BITS;
  localparam int TBL_ENTRIES = TBL_SIZE + 1;
  localparam int ADDR_W      = $clog2(TBL_ENTRIES);
  localparam int COS_FRAC    = 22;
  localparam int COS_W       = COS_FRAC + 1;

  // Datapath widths
  localparam int PROD_W = COEF_W + COEF_W;
  localparam int ACC_W  = PROD_W + 4;
  localparam int RND_W  = ACC_W - COS_FRAC;
  localparam int PAIRS  = (NTERMS + 1) / 2;

  // Register stages from input to output register
  localparam int PIPE_STAGES = 6;

  // Register indexes
  localparam logic [TERM_W-1:0] REG_PHASE_STEP = 3'd0;
  localparam logic [TERM_W-1:0] REG_TERM_COUNT = 3'd1;
  localparam logic [TERM_W-1:0] REG_COEF_ZERO  = 3'd2;
  localparam logic [TERM_W-1:0] REG_COEF_ONE   = 3'd3;
  localparam logic [TERM_W-1:0] REG_COEF_TWO   = 3'd4;
  localparam logic [TERM_W-1:0] REG_COEF_THREE = 3'd5;
  localparam logic [TERM_W-1:0] REG_COEF_FOUR  = 3'd6;

  // Reset values
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd1048576;
  localparam logic [TERM_W-1:0]  TERM_COUNT_RST = 3'd1;
  localparam logic [COEF_W-1:0]  COEF_ONE_Q20   = 24'd1048576;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [COS_W-1:0] cos_tbl_t [TBL_ENTRIES];

  // Quotient of a series term by a small divisor, by shift and subtract
  function automatic longint unsigned div_small(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    int b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series of cos over the first quadrant, evaluated at elaboration
  function automatic cos_tbl_t build_cos_tbl();
    cos_tbl_t tbl;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned ii;
    longint unsigned dv;
    longint s;
    int i;
    int m;
    for (i = 0; i < TBL_ENTRIES; i++) begin
      ii = 64'(i);
      x  = (HALF_PI_Q30 * ii + 64'(TBL_SIZE / 2)) >> TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      s  = 64'sd1 << 30;
      for (m = 1; m <= 12; m++) begin
        dv = 64'((2 * m - 1) * (2 * m));
        t  = div_small((t * x2) >> 30, dv);
        if (m[0]) begin
          s = s - longint'(t);
        end else begin
          s = s + longint'(t);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      if (s > (64'sd1 << 30)) begin
        s = 64'sd1 << 30;
      end
      tbl[i] = COS_W'((64'(s) + 64'd128) >> 8);
    end
    return tbl;
  endfunction

  localparam cos_tbl_t COS_TBL = build_cos_tbl();

endpackage

// ----- src/cswg_if.sv -----
interface cswg_in_if import cswg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink (input valid, input sample_index, output ready);
endinterface

interface cswg_out_if import cswg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] window_value;

  modport source (output valid, output window_value, input ready);
  modport sink (input valid, input window_value, output ready);
endinterface

// ----- src/cswg_ram.sv -----
module cswg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/cosine_sum_window_generator.sv -----
// Generalized cosine-sum window generator. Each accepted sample index yields one
// signed Q3.20 weight, sum of coef_k * cos(k * 2*pi * index * phase_step / 2^32) over
// the first term_count terms, rounded half up and saturated. The pipeline takes one
// index per clock unless the output stalls, through six register stages (input phase
// multiply, cosine table read, coefficient multiply, two adder stages, round and
// saturate). A stalled output holds the pipeline without losing items. Each harmonic
// above the constant term has its own copy of the quarter-wave cosine table, so all
// those lookups happen in the same cycle. After reset the tables are loaded, one entry
// per cycle, and the input stays not ready until the load completes; register writes
// are taken at any time.
module cosine_sum_window_generator import cswg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  cswg_in_if.sink            index_i,
  cswg_out_if.source         window_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0]       phase_step_q;
  logic [TERM_W-1:0]        term_count_q;
  logic signed [COEF_W-1:0] coef_q [COEF_REGS];
  logic [TERM_W-1:0]        reg_idx;
  logic                     cfg_wr;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RST;
      term_count_q <= TERM_COUNT_RST;
      coef_q[0]    <= COEF_ONE_Q20;
      coef_q[1]    <= '0;
      coef_q[2]    <= '0;
      coef_q[3]    <= '0;
      coef_q[4]    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PHASE_STEP: phase_step_q <= pwdata;
        REG_TERM_COUNT: term_count_q <= pwdata[TERM_W-1:0];
        REG_COEF_ZERO:  coef_q[0]    <= pwdata[COEF_W-1:0];
        REG_COEF_ONE:   coef_q[1]    <= pwdata[COEF_W-1:0];
        REG_COEF_TWO:   coef_q[2]    <= pwdata[COEF_W-1:0];
        REG_COEF_THREE: coef_q[3]    <= pwdata[COEF_W-1:0];
        REG_COEF_FOUR:  coef_q[4]    <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_PHASE_STEP: prdata = phase_step_q;
      REG_TERM_COUNT: prdata = {{(DATA_W-TERM_W){1'b0}}, term_count_q};
      REG_COEF_ZERO:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_q[0]};
      REG_COEF_ONE:   prdata = {{(DATA_W-COEF_W){1'b0}}, coef_q[1]};
      REG_COEF_TWO:   prdata = {{(DATA_W-COEF_W){1'b0}}, coef_q[2]};
      REG_COEF_THREE: prdata = {{(DATA_W-COEF_W){1'b0}}, coef_q[3]};
      REG_COEF_FOUR:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_q[4]};
      default:        prdata = '0;
    endcase
  end

  // Cap the term count at the number of built lanes
  logic [TERM_W-1:0] cnt_eff;
  assign cnt_eff = (term_count_q > TERM_W'(NTERMS)) ? TERM_W'(NTERMS) : term_count_q;

  // ---------------------------------------------------------------------------
  // Table load after reset
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] fill_q;
  logic              fill_done_q;
  logic              fill_we;
  logic [COS_W-1:0]  fill_data;

  assign fill_we   = !fill_done_q;
  assign fill_data = COS_TBL[fill_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      fill_done_q <= 1'b0;
    end else if (!fill_done_q) begin
      if (fill_q == ADDR_W'(TBL_SIZE)) begin
        fill_done_q <= 1'b1;
      end else begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage advances when empty or when the next one advances
  // ---------------------------------------------------------------------------
  logic [PIPE_STAGES-1:0] vld_q;
  logic [PIPE_STAGES-1:0] adv;
  logic                   in_acc;

  always_comb begin
    adv[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || window_o.ready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign index_i.ready = adv[0] && fill_done_q;
  assign in_acc        = index_i.valid && index_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_acc;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: base phase = index * step mod 2^32
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0]    phase_q;
  logic [INDEX_BITS-1:0] idx;

  assign idx = index_i.sample_index[INDEX_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_acc) begin
      phase_q <= PHASE_W'(idx * phase_step_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1 and 2: table lookup per harmonic, then coefficient multiply
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_q [NTERMS];

  // Constant term: cos(0) is exactly 1.0 in Q22
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      prod_q[0] <= (cnt_eff != '0) ? (PROD_W'(coef_q[0]) <<< COS_FRAC) : '0;
    end
  end

  for (genvar k = 1; k < NTERMS; k++) begin : g_lane
    logic [PHASE_W-1:0]       lane_phase;
    logic [1:0]               quad;
    logic [TABLE_BITS-1:0]    qaddr;
    logic [ADDR_W-1:0]        raddr;
    logic [COS_W-1:0]         mag;
    logic                     neg_q;
    logic signed [COEF_W-1:0] cos_s;
    logic signed [PROD_W-1:0] mul;
    logic                     use_term;

    // Harmonic phase, folded into the first quadrant
    assign lane_phase = PHASE_W'(phase_q * PHASE_W'(k));
    assign quad       = lane_phase[PHASE_W-1 -: 2];
    assign qaddr      = lane_phase[PHASE_W-3 -: TABLE_BITS];
    assign raddr      = quad[0] ? (ADDR_W'(TBL_SIZE) - ADDR_W'(qaddr)) : ADDR_W'(qaddr);

    cswg_ram #(
      .WIDTH (COS_W),
      .DEPTH (TBL_ENTRIES)
    ) u_cos_ram (
      .clk_i   (clk_i),
      .we_i    (fill_we),
      .waddr_i (fill_q),
      .wdata_i (fill_data),
      .re_i    (adv[1]),
      .raddr_i (raddr),
      .rdata_o (mag)
    );

    // Second and third quadrants are negative
    always_ff @(posedge clk_i) begin
      if (adv[1]) begin
        neg_q <= quad[1] ^ quad[0];
      end
    end

    assign cos_s    = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign mul      = coef_q[k] * cos_s;
    assign use_term = TERM_W'(k) < cnt_eff;

    always_ff @(posedge clk_i) begin
      if (adv[2]) begin
        prod_q[k] <= use_term ? mul : '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pairwise sums
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] pair_q [PAIRS];

  for (genvar j = 0; j < PAIRS; j++) begin : g_pair
    logic signed [ACC_W-1:0] pair_sum;
    if (2 * j + 1 < NTERMS) begin : g_two
      assign pair_sum = ACC_W'(prod_q[2*j]) + ACC_W'(prod_q[2*j+1]);
    end else begin : g_one
      assign pair_sum = ACC_W'(prod_q[2*j]);
    end
    always_ff @(posedge clk_i) begin
      if (adv[3]) begin
        pair_q[j] <= pair_sum;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: total in Q42
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W-1:0] acc_q;

  always_comb begin
    acc_d = '0;
    for (int j = 0; j < PAIRS; j++) begin
      acc_d = acc_d + pair_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      acc_q <= acc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: round half up to Q20, saturate, output register
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [RND_W-1:0] rnd;
  logic [RND_W-VAL_W:0]    rnd_top;
  logic signed [VAL_W-1:0] win_d;
  logic signed [VAL_W-1:0] win_q;

  assign rnd_sum = acc_q + (ACC_W'(1) <<< (COS_FRAC - 1));
  assign rnd     = $signed(rnd_sum[ACC_W-1:COS_FRAC]);
  assign rnd_top = rnd[RND_W-1:VAL_W-1];

  always_comb begin
    if ((&rnd_top) || !(|rnd_top)) begin
      win_d = rnd[VAL_W-1:0];
    end else if (rnd[RND_W-1]) begin
      win_d = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      win_d = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      win_q <= win_d;
    end
  end

  assign window_o.valid        = vld_q[PIPE_STAGES-1];
  assign window_o.window_value = win_q;

endmodule

// ----- src/cswg_checker.sv -----
module cswg_checker import cswg_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [VAL_W-1:0] window_value_i
);

  // Track transactions inside the block
  logic [3:0] inflight_q;
  logic [3:0] inflight_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // No result without an accepted index behind it
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != '0)
    else $error("result shown with no transaction in flight");

  // Never more items inside than pipeline stages
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 4'(PIPE_STAGES))
    else $error("more transactions in flight than pipeline stages");

  // A draining output keeps the input open
  a_throughput: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_ready_i) && out_ready_i |-> in_ready_i)
    else $error("input stalled while output is taken");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(window_value_i))
    else $error("stalled result changed or dropped");

endmodule

bind cosine_sum_window_generator cswg_checker u_cswg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (index_i.valid),
  .in_ready_i     (index_i.ready),
  .out_valid_i    (window_o.valid),
  .out_ready_i    (window_o.ready),
  .window_value_i (window_o.window_value)
);
